>>> rtl/wbps_pkg.sv
// Package for the wildcard byte pattern scanner.
// Holds sizes, configuration register indexes and the transaction payload types.
// No dependencies.
package wbps_pkg;

    localparam int PATTERN_MAX  = 32;
    localparam int OFFSET_WIDTH = 32;
    localparam int MATCH_OFF_W  = 32;
    localparam int BYTE_W       = 8;
    localparam int PAT_REG_W    = 64;
    localparam int PAT_REGS     = 4;
    localparam int WILD_W       = 32;
    localparam int LEN_W        = 6;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int WIN_IDX_W    = $clog2(PATTERN_MAX);
    localparam int FILL_W       = $clog2(PATTERN_MAX + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WILD_MASK  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LENGTH = 3'd5;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              segment_start;
        logic              end_of_scan;
    } scan_in_t;

    typedef struct packed {
        logic                   found;
        logic [MATCH_OFF_W-1:0] match_offset;
        logic                   at_end;
    } scan_res_t;

endpackage

>>> rtl/wildcard_byte_pattern_scanner_top.sv
// Wildcard byte pattern scanner: input register, parallel window compare, result register.
// Depends on wbps_pkg.
//
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+------------------------------------
// in       | in  | in_valid / in_ready  | in_data   (scan_in_t)
// out      | out | out_valid / out_ready| out_data  (scan_res_t)
// cfg      | in  | cfg_we               | cfg_index, cfg_data (64 bits)
//
// One byte per cycle unless the output stalls; each byte is held in the input register and
// its result, if any, is then registered in the output register.
// The window compare of all 32 positions is done in parallel, combinationally.
// Only a result-producing byte waits on a full output register; others pass.
// rst_n resets control state and configuration (length to 1); the byte window is not reset.
module wildcard_byte_pattern_scanner_top
    import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  scan_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output scan_res_t              out_data
);

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    logic [PAT_REGS-1:0][PAT_REG_W-1:0] pattern_reg;
    logic [WILD_W-1:0]                  wild_reg;
    logic [LEN_W-1:0]                   len_reg;

    logic                               in_valid_reg;
    scan_in_t                           in_data_reg;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_reg;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_next;
    logic [FILL_W-1:0]                  fill_reg;
    logic [FILL_W-1:0]                  fill_next;
    logic [FILL_W-1:0]                  fill_base;
    logic [OFFSET_WIDTH-1:0]            offset_reg;
    logic [OFFSET_WIDTH-1:0]            offset_next;
    logic                               reported_reg;
    logic                               reported_next;

    logic                               out_valid_reg;
    scan_res_t                          out_data_reg;

    logic [PAT_REGS*PAT_REG_W-1:0]      pattern_flat;
    logic [LEN_W-1:0]                   len_m1;
    logic [WIN_IDX_W-1:0]               win_idx;
    logic [PATTERN_MAX-1:0]             pos_ok;
    logic                               len_ok;
    logic                               match;
    logic                               produce;
    logic                               advance;
    logic [OFFSET_WIDTH-1:0]            match_start;
    scan_res_t                          result;

    assign pattern_flat = pattern_reg;
    assign len_m1       = len_reg - LEN_W'(1);
    assign len_ok       = (len_reg != '0) && (len_reg <= LEN_W'(PATTERN_MAX));

    // Window shift and match evaluation for the byte in the input register
    always_comb
    begin
        fill_base = in_data_reg.segment_start ? '0 : fill_reg;
        window_next[0] = in_data_reg.data_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        fill_next = (fill_base < FILL_W'(PATTERN_MAX)) ? fill_base + FILL_W'(1) : fill_base;
        win_idx = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            win_idx   = WIN_IDX_W'(len_m1) - WIN_IDX_W'(j);
            pos_ok[j] = (LEN_W'(j) >= len_reg) || wild_reg[j]
                        || (window_next[win_idx] == pattern_flat[j*BYTE_W +: BYTE_W]);
        end
        match = len_ok && (FILL_W'(fill_next) >= FILL_W'(len_reg)) && (&pos_ok);
    end

    always_comb
    begin
        if (offset_reg < OFFSET_WIDTH'(len_m1))
        begin
            match_start = '0;
        end
        else
        begin
            match_start = offset_reg - OFFSET_WIDTH'(len_m1);
        end
        result.found        = match;
        result.match_offset = match ? MATCH_OFF_W'(match_start) : '0;
        result.at_end       = in_data_reg.end_of_scan;
    end

    assign produce  = in_valid_reg && !reported_reg && (match || in_data_reg.end_of_scan);
    assign advance  = in_valid_reg && (!produce || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        reported_next = reported_reg;
        offset_next   = offset_reg;
        if (!reported_reg)
        begin
            reported_next = match || in_data_reg.end_of_scan;
            offset_next   = (offset_reg < OFFSET_MAX) ? offset_reg + OFFSET_WIDTH'(1) : offset_reg;
        end
        if (in_data_reg.end_of_scan)
        begin
            reported_next = 1'b0;
            offset_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            wild_reg    <= '0;
            len_reg     <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_0:  pattern_reg[0] <= cfg_data;
                CFG_PATTERN_1:  pattern_reg[1] <= cfg_data;
                CFG_PATTERN_2:  pattern_reg[2] <= cfg_data;
                CFG_PATTERN_3:  pattern_reg[3] <= cfg_data;
                CFG_WILD_MASK:  wild_reg       <= cfg_data[WILD_W-1:0];
                CFG_PAT_LENGTH: len_reg        <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fill_reg      <= '0;
            offset_reg    <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                offset_reg   <= offset_next;
                reported_reg <= reported_next;
                if (in_data_reg.end_of_scan)
                begin
                    fill_reg <= '0;
                end
                else if (!reported_reg)
                begin
                    fill_reg <= fill_next;
                end
            end
            if (advance && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance && !reported_reg)
        begin
            window_reg <= window_next;
        end
        if (advance && produce)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
